[src/sms_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the spi master byte shifter
// no dependencies; used by every module of the block

package sms_pkg;

   // command codes of a request transaction
   localparam logic CMD_QUEUE = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   // register indexes of the csr port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPI_MODE      = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LSB_FIRST     = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_HALF_PERIOD   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SELECT_MODE   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MANUAL_SELECT = 3'd4;

   // select modes
   localparam logic [1:0] SEL_DISABLED = 2'd0;
   localparam logic [1:0] SEL_AUTO     = 2'd1;
   localparam logic [1:0] SEL_MANUAL   = 2'd2;
   localparam logic [1:0] SEL_RESET    = SEL_AUTO;

   localparam logic [7:0] FILLER_BYTE = 8'hFF;
   localparam logic [2:0] LAST_BIT    = 3'd7;

   typedef struct packed {
      logic       cmd;
      logic [7:0] tx_byte;
      logic       tx_present;
      logic       end_of_transfer;
      logic       miso_level;
   } req_type;

   typedef struct packed {
      logic       sclk_level;
      logic       mosi_level;
      logic       select_n_level;
      logic [7:0] rx_byte;
      logic       rx_done;
      logic       busy_res;
      logic       rejected;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  spi_mode;
      logic        lsb_first;
      logic [15:0] half_period;
      logic [1:0]  select_mode;
      logic        manual_select;
   } cfg_type;

   // spi_mode write strobe seen by the shift engine
   typedef struct packed {
      logic mode_wr;
      logic new_cpol;
   } cfg_evt_type;

endpackage

[src/sms_cfg.sv]
`timescale 1ns / 1ps
// configuration registers of the spi master byte shifter
// depends on sms_pkg

module sms_cfg (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [sms_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [sms_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   output sms_pkg::cfg_type                     cfg,
   output sms_pkg::cfg_evt_type                 evt
);

   sms_pkg::cfg_type cfg_ff;
   sms_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in       = cfg_ff;
      evt.mode_wr  = 1'b0;
      evt.new_cpol = csr_wdata[1];
      if (csr_write_en) begin
         case (csr_index)
            sms_pkg::REG_SPI_MODE: begin
               cfg_in.spi_mode = csr_wdata[1:0];
               evt.mode_wr     = 1'b1;
            end
            sms_pkg::REG_LSB_FIRST:     cfg_in.lsb_first     = csr_wdata[0];
            sms_pkg::REG_HALF_PERIOD:   cfg_in.half_period   = csr_wdata[15:0];
            sms_pkg::REG_SELECT_MODE:   cfg_in.select_mode   = csr_wdata[1:0];
            sms_pkg::REG_MANUAL_SELECT: cfg_in.manual_select = csr_wdata[0];
            default: begin
               // writes beyond the register list are ignored
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.spi_mode      <= 2'd0;
         cfg_ff.lsb_first     <= 1'b0;
         cfg_ff.half_period   <= 16'd0;
         cfg_ff.select_mode   <= sms_pkg::SEL_RESET;
         cfg_ff.manual_select <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[src/sms_engine.sv]
`timescale 1ns / 1ps
// shift engine: divider, bit counter, shift registers and pin levels
// depends on sms_pkg

module sms_engine #(
   parameter int DIVIDER_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  sms_pkg::req_type     req,
   input  sms_pkg::cfg_type     cfg,
   input  sms_pkg::cfg_evt_type evt,
   output sms_pkg::rsp_type     result
);

   logic [DIVIDER_BITS-1:0] tick_count_ff, tick_count_in;
   logic [2:0]              bit_index_ff, bit_index_in;
   logic [7:0]              tx_shift_ff, tx_shift_in;
   logic [7:0]              rx_shift_ff, rx_shift_in;
   logic                    byte_active_ff, byte_active_in;
   logic                    second_half_ff, second_half_in;
   logic                    clock_level_ff, clock_level_in;
   logic                    select_active_ff, select_active_in;
   logic                    release_ff, release_in;

   logic                    cpol, cpha;
   logic [DIVIDER_BITS-1:0] hp;
   logic                    done;
   logic                    rej;
   logic [7:0]              rx_out;
   logic [2:0]              prev_index;

   function automatic logic [2:0] bit_pos(input logic [2:0] idx, input logic lsb);
      return lsb ? idx : (sms_pkg::LAST_BIT - idx);
   endfunction

   assign cpol = cfg.spi_mode[1];
   assign cpha = cfg.spi_mode[0];
   assign hp   = DIVIDER_BITS'(cfg.half_period);

   always_comb begin
      tick_count_in    = tick_count_ff;
      bit_index_in     = bit_index_ff;
      tx_shift_in      = tx_shift_ff;
      rx_shift_in      = rx_shift_ff;
      byte_active_in   = byte_active_ff;
      second_half_in   = second_half_ff;
      clock_level_in   = clock_level_ff;
      select_active_in = select_active_ff;
      release_in       = release_ff;
      done             = 1'b0;
      rej              = 1'b0;
      rx_out           = 8'd0;

      if (accept) begin
         if (req.cmd == sms_pkg::CMD_QUEUE) begin
            if (byte_active_ff) begin
               rej = 1'b1;
            end else begin
               tx_shift_in      = req.tx_present ? req.tx_byte : sms_pkg::FILLER_BYTE;
               rx_shift_in      = 8'd0;
               bit_index_in     = 3'd0;
               tick_count_in    = '0;
               second_half_in   = 1'b0;
               byte_active_in   = 1'b1;
               clock_level_in   = cpol;
               select_active_in = 1'b1;
               release_in       = req.end_of_transfer;
            end
         end else if (byte_active_ff) begin
            if (tick_count_ff >= hp) begin
               tick_count_in = '0;
               if (!second_half_ff) begin
                  // leading edge
                  clock_level_in = ~cpol;
                  if (!cpha && req.miso_level) begin
                     rx_shift_in[bit_pos(bit_index_ff, cfg.lsb_first)] = 1'b1;
                  end
                  second_half_in = 1'b1;
               end else begin
                  // trailing edge
                  clock_level_in = cpol;
                  if (cpha && req.miso_level) begin
                     rx_shift_in[bit_pos(bit_index_ff, cfg.lsb_first)] = 1'b1;
                  end
                  second_half_in = 1'b0;
                  if (bit_index_ff == sms_pkg::LAST_BIT) begin
                     done           = 1'b1;
                     rx_out         = rx_shift_in;
                     byte_active_in = 1'b0;
                     bit_index_in   = 3'd0;
                     if (release_ff) begin
                        select_active_in = 1'b0;
                     end
                     release_in = 1'b0;
                  end else begin
                     bit_index_in = bit_index_ff + 3'd1;
                  end
               end
            end else begin
               tick_count_in = tick_count_ff + DIVIDER_BITS'(1);
            end
         end
      end

      // idle clock follows a mode write at once
      if (evt.mode_wr && !byte_active_ff) begin
         clock_level_in = evt.new_cpol;
      end
   end

   // pin levels from the updated state
   assign prev_index = bit_index_in - 3'd1;

   always_comb begin
      result.sclk_level = clock_level_in;
      if (!byte_active_in) begin
         result.mosi_level = 1'b1;
      end else if (!cpha || second_half_in) begin
         result.mosi_level = tx_shift_in[bit_pos(bit_index_in, cfg.lsb_first)];
      end else if (bit_index_in == 3'd0) begin
         result.mosi_level = 1'b1;
      end else begin
         result.mosi_level = tx_shift_in[bit_pos(prev_index, cfg.lsb_first)];
      end
      case (cfg.select_mode)
         sms_pkg::SEL_AUTO:   result.select_n_level = ~select_active_in;
         sms_pkg::SEL_MANUAL: result.select_n_level = ~cfg.manual_select;
         default:             result.select_n_level = 1'b1;
      endcase
      result.rx_byte  = rx_out;
      result.rx_done  = done;
      result.busy_res = byte_active_in;
      result.rejected = rej;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff    <= '0;
         bit_index_ff     <= 3'd0;
         tx_shift_ff      <= sms_pkg::FILLER_BYTE;
         rx_shift_ff      <= 8'd0;
         byte_active_ff   <= 1'b0;
         second_half_ff   <= 1'b0;
         clock_level_ff   <= 1'b0;
         select_active_ff <= 1'b0;
         release_ff       <= 1'b0;
      end else begin
         tick_count_ff    <= tick_count_in;
         bit_index_ff     <= bit_index_in;
         tx_shift_ff      <= tx_shift_in;
         rx_shift_ff      <= rx_shift_in;
         byte_active_ff   <= byte_active_in;
         second_half_ff   <= second_half_in;
         clock_level_ff   <= clock_level_in;
         select_active_ff <= select_active_in;
         release_ff       <= release_in;
      end
   end

endmodule

[src/spi_master_byte_shifter.sv]
`timescale 1ns / 1ps
// spi master byte shifter: one request transaction a cycle unless stalled, one response each.
// A queue transaction loads a byte (0xFF when no data is present) and a tick
// transaction advances the divider; every half_period+1 ticks the serial
// clock makes one edge, MISO is sampled on the leading edge (CPHA=0) or the
// trailing edge (CPHA=1), and after the eighth bit the received byte comes
// back with rx_done. Each response carries the pin levels after its request.
// Timing: a request is taken every cycle while the response register is free
// or being drained; its response is in the response register in the cycle
// after acceptance. req_stall is raised only when a response waits and
// rsp_stall is high, so throughput is one transaction per cycle when rsp_stall
// is low. The state update is a single pass of the shift engine between the
// state registers and the response register. Config writes are taken at any
// cycle with csr_write_en and must only be issued while the block is idle.
// depends on sms_pkg, sms_cfg, sms_engine

module spi_master_byte_shifter #(
   parameter int DIVIDER_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  sms_pkg::req_type                   req_data,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output sms_pkg::rsp_type                   rsp_data,
   // configuration write port
   input  logic                               csr_write_en,
   input  logic [sms_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [sms_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   sms_pkg::cfg_type     cfg;
   sms_pkg::cfg_evt_type evt;
   sms_pkg::rsp_type     result;
   logic                 accept;

   logic                 rsp_valid_ff, rsp_valid_in;
   sms_pkg::rsp_type     rsp_data_ff;

   // hold off requests only while a response sits unaccepted
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   sms_cfg u_cfg (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg),
      .evt          (evt)
   );

   sms_engine #(
      .DIVIDER_BITS (DIVIDER_BITS)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .cfg    (cfg),
      .evt    (evt),
      .result (result)
   );

   // response register: loads on every accepted transaction
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[src/sms_checker.sv]
`timescale 1ns / 1ps
// port-level checks of the spi master byte shifter, bound to the top level
// depends on sms_pkg and spi_master_byte_shifter

module sms_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input sms_pkg::rsp_type rsp_data,
   input logic             rsp_valid,
   input logic             rsp_stall
);

   // a waiting response holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // a full and stalled response register blocks new requests
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("request accepted over a waiting response");

   // every accepted request yields a response next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted request produced no response");

   // a completed byte ends the shift
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.rx_done |-> !rsp_data.busy_res && !rsp_data.rejected)
      else $error("byte done while still busy");

   // rejection only happens while busy, and rx_byte is zero without done
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_data.rejected || rsp_data.busy_res)
                    && (rsp_data.rx_done || rsp_data.rx_byte == 8'd0))
      else $error("inconsistent response flags");

endmodule

bind spi_master_byte_shifter sms_checker u_sms_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_data  (rsp_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall)
);
